### design/kid_pkg.sv
// ----------------------------------------------------------------------------
// kid_pkg
// Shared widths, register indexes, reset values, item types and command and
// status types of the keyframe index decimator.
// ----------------------------------------------------------------------------
package kid_pkg;

  localparam int CfgW          = 9;
  localparam int CfgIdxW       = 8;
  localparam int DblW          = 64;
  localparam int IntW          = 32;
  localparam int SlotW         = 8;
  localparam int MaxEntriesDef = 256;

  localparam logic [CfgIdxW-1:0] RegEntryTotal = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegKeepLimit  = CfgIdxW'(1);

  localparam logic [CfgW-1:0] EntryTotalRst = CfgW'(0);
  localparam logic [CfgW-1:0] KeepLimitRst  = CfgW'(2);

  typedef struct packed {
    logic [DblW-1:0] position_bits;
    logic [DblW-1:0] time_bits;
  } in_item_t;

  typedef struct packed {
    logic signed [IntW-1:0] file_position;
    logic signed [IntW-1:0] time_value;
    logic [SlotW-1:0]       kept_slot;
    logic                   over_limit;
  } out_item_t;

  typedef struct packed {
    logic cfg_we;
    logic div_load;
    logic div_step;
    logic take;
  } kid_cmd_t;

  typedef struct packed {
    logic keep;
  } kid_sts_t;

endpackage

### design/kid_ctrl.sv
// ----------------------------------------------------------------------------
// kid_ctrl
// Controller: sequences the stride division after a register write and runs
// the input and result handshakes.
// ----------------------------------------------------------------------------
module kid_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  output kid_pkg::kid_cmd_t cmd,
  input  kid_pkg::kid_sts_t sts
);
  import kid_pkg::*;

  localparam logic [1:0] StRun   = 2'd0;
  localparam logic [1:0] StDInit = 2'd1;
  localparam logic [1:0] StDStep = 2'd2;

  localparam int CntW = $clog2(CfgW + 1);

  logic [1:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            cfg_fire;
  logic            take;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign in_ready  = (state_r == StRun) && (!out_valid_r || out_ready);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.cfg_we   = cfg_fire;
    cmd.div_load = 1'b0;
    cmd.div_step = 1'b0;
    cmd.take     = take;
    unique case (state_r)
      StRun: begin
      end
      StDInit: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = StDStep;
      end
      StDStep: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CntW'(1);
        if (cnt_r == CntW'(CfgW - 1)) begin
          state_nxt = StRun;
        end
      end
      default: begin
        state_nxt = StRun;
      end
    endcase
    if (cfg_fire) begin
      state_nxt = StDInit;
    end
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = sts.keep;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StRun;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/kid_dp.sv
// ----------------------------------------------------------------------------
// kid_dp
// Datapath: configuration registers, serial divider for the stride, entry
// selection state and the double to integer conversion of kept items.
// ----------------------------------------------------------------------------
module kid_dp #(
  parameter int MAX_ENTRIES = kid_pkg::MaxEntriesDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kid_pkg::kid_cmd_t          cmd,
  output kid_pkg::kid_sts_t          sts,
  input  logic [kid_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [kid_pkg::CfgW-1:0]   cfg_data,
  input  kid_pkg::in_item_t          in_item,
  output kid_pkg::out_item_t         out_item
);
  import kid_pkg::*;

  function automatic logic [IntW-1:0] dbl_to_int(input logic [DblW-1:0] b);
    logic [10:0] ex;
    logic [51:0] man;
    logic [52:0] shifted;
    logic [10:0] sh;
    logic [IntW-1:0] mag;
    ex      = b[62:52];
    man     = b[51:0];
    sh      = 11'd1075 - ex;
    shifted = {1'b1, man} >> sh[5:0];
    mag     = shifted[IntW-1:0];
    if (ex == 11'h7FF && man != '0) begin
      dbl_to_int = '0;
    end else if (ex < 11'd1023) begin
      dbl_to_int = '0;
    end else if (ex >= 11'd1054) begin
      dbl_to_int = b[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      dbl_to_int = b[63] ? (32'd0 - mag) : mag;
    end
  endfunction

  logic [CfgW-1:0] total_r, limit_r;
  logic [CfgW-1:0] quo_r, quo_nxt;
  logic [CfgW:0]   rem_r, rem_nxt;
  logic [CfgW:0]   trial;

  logic [CfgW-1:0] idx_r, kept_r, surplus_r, phase_r;
  logic            toggle_r;
  logic [CfgW-1:0] idx_nxt, kept_nxt, surplus_nxt, phase_nxt;
  logic            toggle_nxt;

  logic            restart;
  logic            active;
  logic            keep;
  logic [CfgW-1:0] surplus_eff, surplus_init;
  logic [CfgW:0]   stride, phase_inc, kept_inc;
  logic            stopped;

  assign restart = cmd.cfg_we && (cfg_index == RegEntryTotal || cfg_index == RegKeepLimit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= EntryTotalRst;
      limit_r <= KeepLimitRst;
    end else if (cmd.cfg_we) begin
      if (cfg_index == RegEntryTotal) begin
        total_r <= cfg_data;
      end else if (cfg_index == RegKeepLimit) begin
        limit_r <= cfg_data;
      end
    end
  end

  // restoring divider, one quotient bit per step
  assign trial = {rem_r[CfgW-1:0], quo_r[CfgW-1]} - {1'b0, limit_r};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.div_load) begin
      rem_nxt = '0;
      quo_nxt = total_r;
    end else if (cmd.div_step) begin
      if (!trial[CfgW]) begin
        rem_nxt = trial;
      end else begin
        rem_nxt = {rem_r[CfgW-1:0], quo_r[CfgW-1]};
      end
      quo_nxt = {quo_r[CfgW-2:0], !trial[CfgW]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r <= EntryTotalRst / KeepLimitRst;
    end else begin
      quo_r <= quo_nxt;
    end
    rem_r <= rem_nxt;
  end

  always_comb begin
    active       = !(32'(total_r) > 32'(MAX_ENTRIES)) && (limit_r >= CfgW'(2))
                   && (idx_r < total_r);
    surplus_init = (total_r > limit_r) ? (total_r - limit_r) : '0;
    surplus_eff  = (idx_r == '0) ? surplus_init : surplus_r;
    stride       = {1'b0, quo_r} + (CfgW+1)'(1);
    phase_inc    = {1'b0, phase_r} + (CfgW+1)'(1);
    kept_inc     = {1'b0, kept_r} + (CfgW+1)'(1);
    stopped      = (kept_r > CfgW'(2)) && (kept_r >= limit_r);

    keep        = 1'b0;
    surplus_nxt = surplus_eff;
    toggle_nxt  = toggle_r;
    if (total_r <= limit_r || idx_r < CfgW'(2)) begin
      keep = 1'b1;
    end else if (quo_r == CfgW'(1)) begin
      if (surplus_eff != '0 && toggle_r) begin
        surplus_nxt = surplus_eff - CfgW'(1);
      end else begin
        keep = 1'b1;
      end
      toggle_nxt = !toggle_r;
    end else begin
      keep = !stopped && (phase_r == '0);
    end
    keep      = keep && active;
    phase_nxt = (phase_inc >= stride) ? '0 : phase_inc[CfgW-1:0];
    idx_nxt   = idx_r + CfgW'(1);
    kept_nxt  = kept_inc[CfgW-1:0];
  end

  assign sts.keep = keep;

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      idx_r     <= '0;
      kept_r    <= '0;
      toggle_r  <= 1'b0;
      surplus_r <= '0;
      phase_r   <= '0;
    end else if (cmd.take && active) begin
      idx_r     <= idx_nxt;
      toggle_r  <= toggle_nxt;
      surplus_r <= surplus_nxt;
      phase_r   <= phase_nxt;
      if (keep) begin
        kept_r <= kept_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && keep) begin
      out_item.file_position <= $signed(dbl_to_int(in_item.position_bits));
      out_item.time_value    <= $signed(dbl_to_int(in_item.time_bits));
      out_item.kept_slot     <= kept_r[SlotW-1:0];
      out_item.over_limit    <= kept_inc > {1'b0, limit_r};
    end
  end

endmodule

### design/keyframe_index_decimator_core.sv
// ----------------------------------------------------------------------------
// keyframe_index_decimator_core
// Thins a stream of keyframe index entries towards keep_limit entries.
// ----------------------------------------------------------------------------
// usage
//   cfg channel: write entry_total (index 0) and keep_limit (index 1) while
//   the block is idle; each write of either restarts the stream. cfg_ready
//   is always high. after a write the stride quotient total/limit is worked
//   out by a serial divider, one bit per cycle; in_ready stays low meanwhile.
//   in channel: one item per entry, position and time as double bits.
//   out channel: one item per kept entry, registered, valid in the cycle
//   after the input item was accepted. dropped entries give no item.
//   throughput is one entry per cycle outside a division; the single output
//   register lets a new entry in during the cycle the previous result is
//   taken. when the receiver stalls, in_ready drops until the pending result
//   is taken. reset gives entry_total 0, keep_limit 2 and a cleared stream;
//   no division is needed after reset.
// ----------------------------------------------------------------------------
module keyframe_index_decimator_core #(
  parameter int MAX_ENTRIES = kid_pkg::MaxEntriesDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  kid_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output kid_pkg::out_item_t          out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kid_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [kid_pkg::CfgW-1:0]    cfg_data
);
  import kid_pkg::*;

  kid_cmd_t cmd;
  kid_sts_t sts;

  kid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  kid_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_item  (out_item)
  );

endmodule

### design/kid_checker.sv
// ----------------------------------------------------------------------------
// kid_checker
// Port level checks of the keyframe index decimator, bound to the top level.
// ----------------------------------------------------------------------------
module kid_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input kid_pkg::out_item_t out_item,
  input logic               cfg_valid,
  input logic               cfg_ready
);
  import kid_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_cfg_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken while stride is computed");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input taken over a pending result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind keyframe_index_decimator_core kid_checker u_kid_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
